/* sv/rwu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwu_pkg
// Shared sizes, codes and saturation helpers for the RBM weight update engine.
// ----------------------------------------------------------------------------
package rwu_pkg;

    // matrix geometry
    localparam int ROW_COUNT = 64;
    localparam int COL_COUNT = 64;
    localparam int CELLS     = ROW_COUNT * COL_COUNT;
    localparam int ROW_AW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int COL_AW    = (COL_COUNT > 1) ? $clog2(COL_COUNT) : 1;
    localparam int CELL_AW   = (CELLS > 1) ? $clog2(CELLS) : 1;

    // word widths
    localparam int W_W    = 32;
    localparam int STAT_W = 48;
    localparam int UNIT_W = 16;
    localparam int CNT_W  = 16;
    localparam int STEP_W = 37;
    localparam int SUM_W  = 38;

    // shared multiplier operand widths
    localparam int MUL_AW = 17;
    localparam int MUL_BW = 34;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // divider sizes
    localparam int DIV_W  = 64;
    localparam int DIV_DW = 16;
    localparam int DIV_CW = $clog2(DIV_W + 1);

    // actions
    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_LOAD  = 3'd2;
    localparam logic [2:0] ACT_CD    = 3'd3;
    localparam logic [2:0] ACT_ACC   = 3'd4;
    localparam logic [2:0] ACT_APPLY = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_RANGE      = 2'd1;
    localparam logic [1:0] ST_ZERO_COUNT = 2'd2;

    // configuration registers
    localparam int          CFG_IDX_W      = 2;
    localparam logic [1:0]  CFG_LEARN_RATE = 2'd0;
    localparam logic [1:0]  CFG_MOMENTUM   = 2'd1;
    localparam logic [15:0] LR_RESET       = 16'd655;

    // clamp to the signed 32-bit range
    function automatic logic signed [W_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7FFF_FFFF);
        lo = -SUM_W'(33'sh0_8000_0000);
        if (x > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[W_W-1:0];
    endfunction

    // clamp a statistics sum at all ones
    function automatic logic [STAT_W-1:0] sat48(input logic [STAT_W:0] x);
        if (x[STAT_W]) begin
            return '1;
        end
        return x[STAT_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* sv/rwu_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwu_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rwu_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [DATA_W-1:0]                       wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [DATA_W-1:0]                       rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when idle
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* sv/rwu_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwu_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rwu_mul (
    input  wire logic                                aclk,
    input  wire logic signed [rwu_pkg::MUL_AW-1:0]   a,
    input  wire logic signed [rwu_pkg::MUL_BW-1:0]   b,
    output logic      signed [rwu_pkg::MUL_PW-1:0]   p
);
    import rwu_pkg::*;

    // product register
    always_ff @(posedge aclk) begin
        p <= MUL_PW'(a) * MUL_PW'(b);
    end

endmodule
`default_nettype wire

/* sv/rwu_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rwu_div
// Iterative restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module rwu_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [rwu_pkg::DIV_W-1:0]     dividend,
    input  wire logic [rwu_pkg::DIV_DW-1:0]    divisor,
    output logic                               done,
    output logic      [rwu_pkg::DIV_W-1:0]     quotient
);
    import rwu_pkg::*;

    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dsr_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   trial;
    logic              ge;

    // trial subtraction
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? DIV_DW'(trial - {1'b0, dsr_reg}) : trial[DIV_DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

/* sv/rbm_weight_update_engine_unit.sv */
`default_nettype none
// Write, read, load and unknown words go from idle straight to the result state; a row
// update, a statistics row and apply step each cell through fetch and their own states.
// Throughput: one word at a time, set by the sequencer over the shared multiplier and
// the one-bit-per-cycle divider; the memories give one read-modify-write per cell.
// Reset: a clearing pass over every cell zeroes all stores; no word is taken
// meanwhile. Clear-only apply makes the same pass but zeroes only the statistics and their counts.
// ----------------------------------------------------------------------------
// rbm_weight_update_engine_unit
// RBM weight matrix with contrastive-divergence and batch statistics updates,
// momentum increments and saturation, run by a small sequencer.
// ----------------------------------------------------------------------------
module rbm_weight_update_engine_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [rwu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [15:0]                          cfg_data,
    // input words
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [2:0]                           s_action,
    input  wire logic [5:0]                           s_row,
    input  wire logic [5:0]                           s_col,
    input  wire logic signed [31:0]                   s_write_value,
    input  wire logic [15:0]                          s_up_pos,
    input  wire logic [15:0]                          s_up_neg,
    input  wire logic [15:0]                          s_down_pos,
    input  wire logic [15:0]                          s_down_neg,
    input  wire logic                                 s_negative_phase,
    input  wire logic                                 s_sample_done,
    input  wire logic                                 s_clear_only,
    // result words
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [31:0]                        m_read_value,
    output logic [1:0]                                m_status
);
    import rwu_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE   = 18'b000000000000000001,
        S_CLEAR  = 18'b000000000000000010,
        S_FETCH  = 18'b000000000000000100,
        S_CD_A   = 18'b000000000000001000,
        S_CD_B   = 18'b000000000000010000,
        S_CD_C   = 18'b000000000000100000,
        S_CD_D   = 18'b000000000001000000,
        S_CD_E   = 18'b000000000010000000,
        S_ACC_A  = 18'b000000000100000000,
        S_ACC_B  = 18'b000000001000000000,
        S_AP_LO  = 18'b000000010000000000,
        S_AP_HI  = 18'b000000100000000000,
        S_AP_CAT = 18'b000001000000000000,
        S_AP_DIV = 18'b000010000000000000,
        S_UPD_A  = 18'b000100000000000000,
        S_UPD_B  = 18'b001000000000000000,
        S_UPD_C  = 18'b010000000000000000,
        S_DONE   = 18'b100000000000000000
    } state_t;

    state_t state_reg;

    // control and payload registers
    logic [2:0]              act_reg;
    logic [1:0]              status_reg;
    logic                    neg_reg;
    logic                    full_reg;
    logic                    row_op_reg;
    logic                    ph_reg;
    logic [CELL_AW-1:0]      addr_reg;
    logic [COL_AW-1:0]       j_reg;
    logic [UNIT_W-1:0]       dnp_reg;
    logic [UNIT_W-1:0]       dnn_reg;
    logic signed [MUL_BW-1:0] t_reg;
    logic signed [MUL_BW-1:0] d_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic signed [W_W-1:0]   inc_reg;
    logic [39:0]             lo_reg;
    logic [15:0]             lr_reg;
    logic [15:0]             mg_reg;
    logic [CNT_W-1:0]        pos_cnt_reg;
    logic [CNT_W-1:0]        neg_cnt_reg;
    logic                    m_valid_reg;
    logic signed [W_W-1:0]   m_value_reg;
    logic [1:0]              m_status_reg;

    // memory ports
    logic                    w_we, w_re, inc_we, pos_we, neg_we, buf_we;
    logic signed [W_W-1:0]   w_wd, inc_wd;
    logic [STAT_W-1:0]       pos_wd, neg_wd;
    logic signed [W_W-1:0]   w_q, inc_q;
    logic [STAT_W-1:0]       pos_q, neg_q;
    logic [UNIT_W-1:0]       upp_q, upn_q;
    logic [CELL_AW-1:0]      cell_addr;
    logic [COL_AW-1:0]       buf_addr;
    logic                    stat_re;

    // shared units
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;
    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [DIV_DW-1:0]        div_divisor;
    logic                     div_done;
    logic [DIV_W-1:0]         div_q;

    // helpers
    logic                    s_accept;
    logic                    row_ok, col_ok;
    logic [CELL_AW-1:0]      port_cell;
    logic [CELL_AW-1:0]      port_base;
    logic                    is_apply;
    logic                    cell_end;
    logic                    last_cell;
    logic [STAT_W-1:0]       stat_sel;
    logic signed [MUL_PW-1:0] rnd_sum;
    logic signed [MUL_PW-1:0] mom_sum;
    logic signed [SUM_W-1:0] mom_m;
    logic signed [W_W-1:0]   inc_new;
    logic signed [W_W-1:0]   w_plain;
    logic signed [W_W-1:0]   w_mom;
    logic [DIV_W:0]          term_sum;
    logic signed [STEP_W-1:0] term;
    logic [STAT_W:0]         acc_sum;

    assign s_accept  = s_valid && (state_reg == S_IDLE);
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign row_ok    = 32'(s_row) < ROW_COUNT;
    assign col_ok    = 32'(s_col) < COL_COUNT;
    assign port_base = CELL_AW'(32'(s_row) * COL_COUNT);
    assign port_cell = CELL_AW'(32'(s_row) * COL_COUNT + 32'(s_col));
    assign is_apply  = (act_reg == ACT_APPLY);
    assign stat_sel  = ph_reg ? pos_q : neg_q;
    assign last_cell = (state_reg != S_CLEAR && row_op_reg)
                       ? (j_reg == COL_AW'(COL_COUNT - 1))
                       : (addr_reg == CELL_AW'(CELLS - 1));

    // arithmetic around the shared multiplier
    assign rnd_sum  = mul_p + MUL_PW'(64'sd536870912);
    assign mom_sum  = mul_p + MUL_PW'(64'sd32768);
    assign mom_m    = SUM_W'(mom_sum >>> 16);
    assign inc_new  = sat32(mom_m + SUM_W'(step_reg));
    assign w_plain  = sat32(SUM_W'(w_q) + SUM_W'(step_reg));
    assign w_mom    = sat32(SUM_W'(w_q) + SUM_W'(inc_reg));
    assign term_sum = {1'b0, div_q} + (DIV_W+1)'(64'd536870912);
    assign term     = $signed({2'b00, term_sum[DIV_W:30]});
    assign acc_sum  = {1'b0, (neg_reg ? neg_q : pos_q)} + (STAT_W+1)'(mul_p[32:0]);
    assign div_dividend = {mul_p[39:0], 24'b0} + {24'b0, lo_reg};
    assign div_divisor  = ph_reg ? pos_cnt_reg : neg_cnt_reg;
    assign div_start    = (state_reg == S_AP_CAT);

    assign cell_end = (state_reg == S_CLEAR) || (state_reg == S_ACC_B)
                      || (state_reg == S_UPD_C)
                      || (state_reg == S_UPD_A && mg_reg == 16'd0);

    // multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_CD_A: begin
                mul_a = $signed({1'b0, dnn_reg});
                mul_b = $signed({18'b0, upn_q});
            end
            S_CD_B: begin
                mul_a = $signed({1'b0, dnp_reg});
                mul_b = $signed({18'b0, upp_q});
            end
            S_CD_D: begin
                mul_a = $signed({1'b0, lr_reg});
                mul_b = d_reg;
            end
            S_ACC_A: begin
                mul_a = $signed({1'b0, (neg_reg ? dnn_reg : dnp_reg)});
                mul_b = $signed({18'b0, (neg_reg ? upn_q : upp_q)});
            end
            S_AP_LO: begin
                mul_a = $signed({1'b0, lr_reg});
                mul_b = $signed({10'b0, stat_sel[23:0]});
            end
            S_AP_HI: begin
                mul_a = $signed({1'b0, lr_reg});
                mul_b = $signed({10'b0, stat_sel[47:24]});
            end
            S_UPD_A: begin
                mul_a = $signed({1'b0, mg_reg});
                mul_b = MUL_BW'(inc_q);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // memory control
    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_wd    = w_plain;
        inc_we  = 1'b0;
        inc_wd  = inc_new;
        pos_we  = 1'b0;
        neg_we  = 1'b0;
        pos_wd  = '0;
        neg_wd  = '0;
        buf_we  = 1'b0;
        stat_re = 1'b0;
        cell_addr = (state_reg == S_IDLE) ? port_cell : addr_reg;
        buf_addr  = (state_reg == S_IDLE) ? COL_AW'(s_col)
                  : (state_reg == S_CLEAR) ? addr_reg[COL_AW-1:0] : j_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    w_we   = (s_action == ACT_WRITE) && row_ok && col_ok;
                    w_wd   = s_write_value;
                    w_re   = (s_action == ACT_READ);
                    buf_we = (s_action == ACT_LOAD) && col_ok;
                end
            end
            S_FETCH: begin
                w_re    = 1'b1;
                stat_re = 1'b1;
            end
            S_CLEAR: begin
                pos_we = 1'b1;
                neg_we = 1'b1;
                if (full_reg) begin
                    w_we   = 1'b1;
                    w_wd   = '0;
                    inc_we = 1'b1;
                    inc_wd = '0;
                    buf_we = 32'(addr_reg) < COL_COUNT;
                end
            end
            S_ACC_B: begin
                pos_we = !neg_reg;
                neg_we = neg_reg;
                pos_wd = sat48(acc_sum);
                neg_wd = sat48(acc_sum);
            end
            S_UPD_A: begin
                if (mg_reg == 16'd0) begin
                    w_we   = 1'b1;
                    pos_we = is_apply;
                    neg_we = is_apply;
                end
            end
            S_UPD_B: begin
                inc_we = 1'b1;
            end
            S_UPD_C: begin
                w_we   = 1'b1;
                w_wd   = w_mom;
                pos_we = is_apply;
                neg_we = is_apply;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            full_reg     <= 1'b1;
            row_op_reg   <= 1'b0;
            addr_reg     <= '0;
            j_reg        <= '0;
            act_reg      <= ACT_WRITE;
            status_reg   <= ST_OK;
            ph_reg       <= 1'b0;
            lr_reg       <= LR_RESET;
            mg_reg       <= 16'd0;
            pos_cnt_reg  <= '0;
            neg_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_valid) begin
                if (cfg_index == CFG_LEARN_RATE) begin
                    lr_reg <= cfg_data;
                end else if (cfg_index == CFG_MOMENTUM) begin
                    mg_reg <= cfg_data;
                end
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // advance over cells
            if (cell_end) begin
                if (last_cell) begin
                    if (state_reg == S_CLEAR && full_reg) begin
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_DONE;
                    end
                    if (is_apply) begin
                        pos_cnt_reg <= '0;
                        neg_cnt_reg <= '0;
                    end
                end else begin
                    addr_reg  <= addr_reg + 1'b1;
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= (state_reg == S_CLEAR) ? S_CLEAR : S_FETCH;
                end
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        act_reg    <= s_action;
                        neg_reg    <= s_negative_phase;
                        dnp_reg    <= s_down_pos;
                        dnn_reg    <= s_down_neg;
                        j_reg      <= '0;
                        row_op_reg <= (s_action == ACT_CD) || (s_action == ACT_ACC);
                        status_reg <= ST_OK;
                        state_reg  <= S_DONE;
                        case (s_action)
                            ACT_WRITE, ACT_READ: begin
                                if (!(row_ok && col_ok)) begin
                                    status_reg <= ST_RANGE;
                                end
                            end
                            ACT_LOAD: begin
                                if (!col_ok) begin
                                    status_reg <= ST_RANGE;
                                end
                            end
                            ACT_CD, ACT_ACC: begin
                                if (!row_ok) begin
                                    status_reg <= ST_RANGE;
                                end else begin
                                    addr_reg  <= port_base;
                                    state_reg <= S_FETCH;
                                    if (s_action == ACT_ACC && s_sample_done) begin
                                        if (s_negative_phase) begin
                                            if (neg_cnt_reg != '1) begin
                                                neg_cnt_reg <= neg_cnt_reg + 1'b1;
                                            end
                                        end else if (pos_cnt_reg != '1) begin
                                            pos_cnt_reg <= pos_cnt_reg + 1'b1;
                                        end
                                    end
                                end
                            end
                            ACT_APPLY: begin
                                addr_reg <= '0;
                                if (s_clear_only) begin
                                    full_reg    <= 1'b0;
                                    pos_cnt_reg <= '0;
                                    neg_cnt_reg <= '0;
                                    state_reg   <= S_CLEAR;
                                end else begin
                                    state_reg <= S_FETCH;
                                    if (pos_cnt_reg == '0 || neg_cnt_reg == '0) begin
                                        status_reg <= ST_ZERO_COUNT;
                                    end
                                end
                            end
                            default: begin
                                status_reg <= ST_OK;
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    step_reg <= '0;
                    if (act_reg == ACT_CD) begin
                        state_reg <= S_CD_A;
                    end else if (act_reg == ACT_ACC) begin
                        state_reg <= S_ACC_A;
                    end else if (neg_cnt_reg != '0) begin
                        ph_reg    <= 1'b0;
                        state_reg <= S_AP_LO;
                    end else if (pos_cnt_reg != '0) begin
                        ph_reg    <= 1'b1;
                        state_reg <= S_AP_LO;
                    end else begin
                        state_reg <= S_UPD_A;
                    end
                end
                S_CD_A: state_reg <= S_CD_B;
                S_CD_B: begin
                    t_reg     <= mul_p[MUL_BW-1:0];
                    state_reg <= S_CD_C;
                end
                S_CD_C: begin
                    d_reg     <= t_reg - mul_p[MUL_BW-1:0];
                    state_reg <= S_CD_D;
                end
                S_CD_D: state_reg <= S_CD_E;
                S_CD_E: begin
                    step_reg  <= STEP_W'(rnd_sum >>> 30);
                    state_reg <= S_UPD_A;
                end
                S_ACC_A: state_reg <= S_ACC_B;
                S_AP_LO: state_reg <= S_AP_HI;
                S_AP_HI: begin
                    lo_reg    <= mul_p[39:0];
                    state_reg <= S_AP_CAT;
                end
                S_AP_CAT: state_reg <= S_AP_DIV;
                S_AP_DIV: begin
                    if (div_done) begin
                        step_reg <= ph_reg ? step_reg - term : step_reg + term;
                        if (!ph_reg && pos_cnt_reg != '0) begin
                            ph_reg    <= 1'b1;
                            state_reg <= S_AP_LO;
                        end else begin
                            state_reg <= S_UPD_A;
                        end
                    end
                end
                S_UPD_A: begin
                    if (mg_reg != 16'd0) begin
                        state_reg <= S_UPD_B;
                    end
                end
                S_UPD_B: begin
                    inc_reg   <= inc_new;
                    state_reg <= S_UPD_C;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_value_reg  <= (act_reg == ACT_READ && status_reg == ST_OK)
                                        ? w_q : '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    if (!cell_end) begin
                        state_reg <= state_reg;
                    end
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_value_reg;
    assign m_status     = m_status_reg;

    // stores
    rwu_ram #(.DATA_W(W_W), .DEPTH(CELLS)) u_weight (
        .aclk(aclk), .we(w_we), .waddr(cell_addr), .wdata(w_wd),
        .re(w_re), .raddr(cell_addr), .rdata(w_q)
    );

    rwu_ram #(.DATA_W(W_W), .DEPTH(CELLS)) u_incr (
        .aclk(aclk), .we(inc_we), .waddr(cell_addr), .wdata(inc_wd),
        .re(stat_re), .raddr(cell_addr), .rdata(inc_q)
    );

    rwu_ram #(.DATA_W(STAT_W), .DEPTH(CELLS)) u_pos_stats (
        .aclk(aclk), .we(pos_we), .waddr(cell_addr), .wdata(pos_wd),
        .re(stat_re), .raddr(cell_addr), .rdata(pos_q)
    );

    rwu_ram #(.DATA_W(STAT_W), .DEPTH(CELLS)) u_neg_stats (
        .aclk(aclk), .we(neg_we), .waddr(cell_addr), .wdata(neg_wd),
        .re(stat_re), .raddr(cell_addr), .rdata(neg_q)
    );

    rwu_ram #(.DATA_W(UNIT_W), .DEPTH(COL_COUNT)) u_up_pos (
        .aclk(aclk), .we(buf_we), .waddr(buf_addr),
        .wdata((state_reg == S_CLEAR) ? '0 : s_up_pos),
        .re(stat_re), .raddr(buf_addr), .rdata(upp_q)
    );

    rwu_ram #(.DATA_W(UNIT_W), .DEPTH(COL_COUNT)) u_up_neg (
        .aclk(aclk), .we(buf_we), .waddr(buf_addr),
        .wdata((state_reg == S_CLEAR) ? '0 : s_up_neg),
        .re(stat_re), .raddr(buf_addr), .rdata(upn_q)
    );

    // shared arithmetic
    rwu_mul u_mul (
        .aclk(aclk), .a(mul_a), .b(mul_b), .p(mul_p)
    );

    rwu_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_dividend), .divisor(div_divisor),
        .done(div_done), .quotient(div_q)
    );

endmodule
`default_nettype wire
